### src/epss_pkg.sv
package epss_pkg;

  // field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned GAMMA_W  = 17;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DVD_W    = WORD_W + FRAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  // configuration register indexes
  localparam logic [1:0] CFG_SECOND_ORDER = 2'd0;
  localparam logic [1:0] CFG_GAMMA_M1     = 2'd1;
  localparam logic [1:0] CFG_INV_TWO_DX   = 2'd2;
  localparam int unsigned CFG_IDX_W       = 2;

  // configuration reset values
  localparam logic               RST_SECOND_ORDER = 1'b1;
  localparam logic [GAMMA_W-1:0] RST_GAMMA_M1     = 17'd26214;
  localparam logic [WORD_W-1:0]  RST_INV_TWO_DX   = 32'd65536;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### src/epss_in_if.sv
interface epss_in_if;
  import epss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     first_cell;
  logic [WORD_W-1:0]        density;
  logic signed [WORD_W-1:0] momentum;
  logic [WORD_W-1:0]        total_energy;

  modport source (output valid, first_cell, density, momentum, total_energy, input ready);
  modport sink   (input valid, first_cell, density, momentum, total_energy, output ready);
endinterface

### src/epss_out_if.sv
interface epss_out_if;
  import epss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] density_slope;
  logic signed [WORD_W-1:0] velocity_slope;
  logic signed [WORD_W-1:0] pressure_slope;
  logic                     bad_density;

  modport source (output valid, density_slope, velocity_slope, pressure_slope, bad_density,
                  input ready);
  modport sink   (input valid, density_slope, velocity_slope, pressure_slope, bad_density,
                  output ready);
endinterface

### src/epss_div.sv
// restoring divider, one quotient bit per cycle
module epss_div import epss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_sts_t          sts,
  output logic [DVD_W-1:0]  quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DVD_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    dvs_r, dvs_nxt;

  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic                 fits;

  // one trial subtract per step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

  // a run ends with exactly one done pulse
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a run");

  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !ctl.start && cnt_r != LAST_STEP |=> busy_r)
    else $error("divider stopped early");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r && cnt_r == '0)
    else $error("divider did not start");

endmodule

### src/euler_primitive_slope_stencil_top.sv
// Central-difference slope stencil for a stream of 1D Euler cells in Q16.16.
// Each cell is turned into primitives (velocity = momentum/density, pressure =
// (gamma-1)(energy - density*u^2/2)); once a row holds three cells, every new
// cell yields the slopes of density, velocity and pressure at the middle cell,
// scaled by inv_two_dx and saturated to 32 bits (all zero in first-order mode).
// One cell is taken at a time: ready is low from acceptance until the cell is
// done, plus any wait for the result slot to drain, and the next beat is taken
// once the block is back in idle. The pace is set by the 48-step restoring
// divider for the velocity and by one shared 32x32 multiplier with a
// registered product, used up to eight times per cell.
// Configuration: index 0 second_order, 1 gamma_minus_one, 2 inv_two_dx; a write
// to index 3 is ignored. Write only while the block is idle.
module euler_primitive_slope_stencil_top import epss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  epss_in_if.sink              in_s,
  epss_out_if.source           out_s,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_U2   = 4'd2;
  localparam logic [3:0] S_K0   = 4'd3;
  localparam logic [3:0] S_K1   = 4'd4;
  localparam logic [3:0] S_K2   = 4'd5;
  localparam logic [3:0] S_D    = 4'd6;
  localparam logic [3:0] S_P0   = 4'd7;
  localparam logic [3:0] S_P1   = 4'd8;
  localparam logic [3:0] S_P2   = 4'd9;
  localparam logic [3:0] S_WIN  = 4'd10;
  localparam logic [3:0] S_M0   = 4'd11;
  localparam logic [3:0] S_M1   = 4'd12;
  localparam logic [3:0] S_M2   = 4'd13;
  localparam logic [3:0] S_M3   = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam int unsigned SUM_W = 2 * WORD_W + FRAC_W;
  localparam int unsigned KE_W  = SUM_W - FRAC_W - 1;
  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MAG = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [DVD_W-1:0]  D_CLAMP = {1'b1, {(DVD_W-1){1'b0}}};

  // signed saturation of a magnitude
  function automatic logic [WORD_W-1:0] sat32(input logic neg, input logic [2*WORD_W-1:0] mag);
    logic [WORD_W-1:0] res;
    if (!neg) begin
      res = (mag > {{WORD_W{1'b0}}, POS_MAX}) ? POS_MAX : mag[WORD_W-1:0];
    end else begin
      res = (mag >= {{WORD_W{1'b0}}, NEG_MAG}) ? NEG_MAG : (~mag[WORD_W-1:0] + 1'b1);
    end
    return res;
  endfunction

  logic [3:0]         state_r, state_nxt;

  // configuration
  logic               second_order_r;
  logic [GAMMA_W-1:0] gm1_r;
  logic [WORD_W-1:0]  inv_r;

  // current cell
  logic               first_r;
  logic [WORD_W-1:0]  rho_r;
  logic [WORD_W-1:0]  energy_r;
  logic               mneg_r;
  logic               bad_r;
  logic [WORD_W-1:0]  umag_r;
  logic [WORD_W-1:0]  vel_r;
  logic [DVD_W-1:0]   u2_r;
  logic [KE_W-1:0]    ke_r;
  logic               dneg_r;
  logic [DVD_W-1:0]   dmag_r;
  logic [WORD_W-1:0]  pres_r;

  // shared multiplier
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] prod_r;
  logic [2*WORD_W-1:0] acc_r;
  logic [SUM_W-1:0]    sum;

  // window
  logic [WORD_W-1:0]  wd_r [2];
  logic [WORD_W-1:0]  wv_r [2];
  logic [WORD_W-1:0]  wp_r [2];
  logic [1:0]         wbad_r;
  logic [1:0]         cells_seen_r;
  logic [1:0]         cells_eff;
  logic               produce;

  // slope operands and results
  logic [WORD_W-1:0]  sdm_r [3];
  logic [2:0]         sneg_r;
  logic [WORD_W-1:0]  slope_r [3];
  logic               rbad_r;

  // output slot
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_d_r, out_v_r, out_p_r;
  logic               out_bad_r;

  // divider
  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  logic [DVD_W-1:0]   div_q;
  logic [WORD_W-1:0]  mmag;
  logic [WORD_W-1:0]  vlim;
  logic               in_acc;
  logic               slot_free;

  logic               dd_ge, dv_ge, dp_ge;
  logic               ke_gt;
  logic [KE_W-1:0]    ke_diff, en_diff;

  assign in_acc     = in_s.valid && in_s.ready;
  assign in_s.ready = (state_r == S_IDLE);
  assign slot_free  = !out_valid_r || out_s.ready;

  assign mmag = in_s.momentum[WORD_W-1] ? (~in_s.momentum + 1'b1) : in_s.momentum;
  assign div_ctl.start = in_acc;

  epss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend ({mmag, {FRAC_W{1'b0}}}),
    .divisor  (in_s.density),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_order_r <= RST_SECOND_ORDER;
      gm1_r          <= RST_GAMMA_M1;
      inv_r          <= RST_INV_TWO_DX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECOND_ORDER: second_order_r <= cfg_wdata[0];
        CFG_GAMMA_M1:     gm1_r          <= cfg_wdata[GAMMA_W-1:0];
        CFG_INV_TWO_DX:   inv_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_U2: begin
        mul_a = umag_r;
        mul_b = umag_r;
      end
      S_K0: begin
        mul_a = rho_r;
        mul_b = prod_r[FRAC_W +: WORD_W];
      end
      S_K1: begin
        mul_a = rho_r;
        mul_b = {{(WORD_W-FRAC_W){1'b0}}, u2_r[DVD_W-1:WORD_W]};
      end
      S_P0: begin
        mul_a = dmag_r[WORD_W-1:0];
        mul_b = {{(WORD_W-GAMMA_W){1'b0}}, gm1_r};
      end
      S_P1: begin
        mul_a = {{(WORD_W-FRAC_W){1'b0}}, dmag_r[DVD_W-1:WORD_W]};
        mul_b = {{(WORD_W-GAMMA_W){1'b0}}, gm1_r};
      end
      S_M0: begin
        mul_a = sdm_r[0];
        mul_b = inv_r;
      end
      S_M1: begin
        mul_a = sdm_r[1];
        mul_b = inv_r;
      end
      S_M2: begin
        mul_a = sdm_r[2];
        mul_b = inv_r;
      end
      default: ;
    endcase
  end

  // combine the low and high partial products
  assign sum = {{FRAC_W{1'b0}}, acc_r} + {prod_r[DVD_W-1:0], {WORD_W{1'b0}}};

  // velocity limit and energy difference
  assign vlim    = mneg_r ? NEG_MAG : POS_MAX;
  assign ke_gt   = ke_r > {{(KE_W-WORD_W){1'b0}}, energy_r};
  assign ke_diff = ke_r - {{(KE_W-WORD_W){1'b0}}, energy_r};
  assign en_diff = {{(KE_W-WORD_W){1'b0}}, energy_r} - ke_r;

  // window compares
  assign dd_ge = rho_r >= wd_r[0];
  assign dv_ge = $signed(vel_r) >= $signed(wv_r[0]);
  assign dp_ge = $signed(pres_r) >= $signed(wp_r[0]);
  assign cells_eff = first_r ? 2'd0 : cells_seen_r;
  assign produce   = (cells_eff == 2'd2);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DIV;
      S_DIV:  if (div_sts.done) state_nxt = S_U2;
      S_U2:   state_nxt = S_K0;
      S_K0:   state_nxt = S_K1;
      S_K1:   state_nxt = S_K2;
      S_K2:   state_nxt = S_D;
      S_D:    state_nxt = S_P0;
      S_P0:   state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_WIN;
      S_WIN: begin
        priority if (!produce) state_nxt = S_IDLE;
        else if (second_order_r) state_nxt = S_M0;
        else state_nxt = S_OUT;
      end
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_OUT;
      S_OUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // cell datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      first_r  <= in_s.first_cell;
      rho_r    <= in_s.density;
      energy_r <= in_s.total_energy;
      mneg_r   <= in_s.momentum[WORD_W-1];
      bad_r    <= (in_s.density == '0);
    end
    unique case (state_r)
      S_DIV: begin
        if (bad_r) begin
          umag_r <= '0;
        end else if (div_q > {{FRAC_W{1'b0}}, vlim}) begin
          umag_r <= vlim;
        end else begin
          umag_r <= div_q[WORD_W-1:0];
        end
      end
      S_U2: vel_r <= mneg_r ? (~umag_r + 1'b1) : umag_r;
      S_K0: u2_r <= prod_r[2*WORD_W-1:FRAC_W];
      S_K1: acc_r <= prod_r;
      S_K2: ke_r <= sum[SUM_W-1:FRAC_W+1];
      S_D: begin
        dneg_r <= ke_gt;
        if ((ke_gt ? ke_diff : en_diff) > {{(KE_W-DVD_W){1'b0}}, D_CLAMP}) begin
          dmag_r <= D_CLAMP;
        end else begin
          dmag_r <= ke_gt ? ke_diff[DVD_W-1:0] : en_diff[DVD_W-1:0];
        end
      end
      S_P1: acc_r <= prod_r;
      S_P2: pres_r <= sat32(dneg_r, sum[FRAC_W +: 2*WORD_W]);
      S_WIN: begin
        // differences against the left cell of the old window
        sneg_r[0] <= !dd_ge;
        sneg_r[1] <= !dv_ge;
        sneg_r[2] <= !dp_ge;
        sdm_r[0]  <= dd_ge ? (rho_r - wd_r[0]) : (wd_r[0] - rho_r);
        sdm_r[1]  <= dv_ge ? (vel_r - wv_r[0]) : (wv_r[0] - vel_r);
        sdm_r[2]  <= dp_ge ? (pres_r - wp_r[0]) : (wp_r[0] - pres_r);
        rbad_r    <= second_order_r && (wbad_r[0] || wbad_r[1] || bad_r);
        slope_r[0] <= '0;
        slope_r[1] <= '0;
        slope_r[2] <= '0;
      end
      S_M1: slope_r[0] <= sat32(sneg_r[0], {{FRAC_W{1'b0}}, prod_r[2*WORD_W-1:FRAC_W]});
      S_M2: slope_r[1] <= sat32(sneg_r[1], {{FRAC_W{1'b0}}, prod_r[2*WORD_W-1:FRAC_W]});
      S_M3: slope_r[2] <= sat32(sneg_r[2], {{FRAC_W{1'b0}}, prod_r[2*WORD_W-1:FRAC_W]});
      default: ;
    endcase
  end

  // window shift and row fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r[0]      <= '0;
      wd_r[1]      <= '0;
      wv_r[0]      <= '0;
      wv_r[1]      <= '0;
      wp_r[0]      <= '0;
      wp_r[1]      <= '0;
      wbad_r       <= '0;
      cells_seen_r <= '0;
    end else if (state_r == S_WIN) begin
      wd_r[0]      <= wd_r[1];
      wd_r[1]      <= rho_r;
      wv_r[0]      <= wv_r[1];
      wv_r[1]      <= vel_r;
      wp_r[0]      <= wp_r[1];
      wp_r[1]      <= pres_r;
      wbad_r       <= {bad_r, wbad_r[1]};
      cells_seen_r <= produce ? 2'd2 : (cells_eff + 2'd1);
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && slot_free) begin
      out_d_r   <= slope_r[0];
      out_v_r   <= slope_r[1];
      out_p_r   <= slope_r[2];
      out_bad_r <= rbad_r;
    end
  end

  assign out_s.valid          = out_valid_r;
  assign out_s.density_slope  = out_d_r;
  assign out_s.velocity_slope = out_v_r;
  assign out_s.pressure_slope = out_p_r;
  assign out_s.bad_density    = out_bad_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == S_DIV)
    else $error("divider done outside the divide step");

  // an accepted beat starts the divider
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> div_sts.busy && state_r == S_DIV)
    else $error("accepted beat did not start a divide");

  // fill count saturates at two
  a_cells_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cells_seen_r != 2'd3)
    else $error("row fill count overflow");

  // a result waits while the slot is still held
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_s.ready |=> state_r == S_OUT && out_valid_r)
    else $error("result overwrote a pending beat");

endmodule
